// ===== rtl/nstp_pkg.sv =====
// ----------------------------------------------------------------------------
// nstp_pkg: shared types and constants of the nested scope time profiler
// Sizes of the stacks, statistics and history, codes and saturating adders.
// ----------------------------------------------------------------------------
package nstp_pkg;

  localparam int THREADS     = 4;
  localparam int ENTRIES     = 16;
  localparam int HISTORY_LEN = 64;
  localparam int STK_DEPTH   = 256;

  localparam int TH_W    = $clog2(THREADS);
  localparam int ENT_W   = $clog2(ENTRIES);
  localparam int SLOT_W  = $clog2(HISTORY_LEN);
  localparam int STK_AW  = $clog2(STK_DEPTH);
  localparam int DEPTH_W = STK_AW + 1;

  localparam int TIME_W  = 48;
  localparam int CALLS_W = 32;
  localparam int TS_W    = 32;

  // operation codes
  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_END   = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // status codes
  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_OVF = 2'd1;
  localparam logic [1:0] STAT_UNF = 2'd2;

  typedef struct packed {
    logic [TS_W-1:0]  mark;
    logic [ENT_W-1:0] ent;
  } stk_item_t;

  typedef struct packed {
    logic [CALLS_W-1:0] calls;
    logic [TIME_W-1:0]  sum;
    logic [TIME_W-1:0]  own;
  } stat_rec_t;

  function automatic logic [TIME_W-1:0] sat_time(input logic [TIME_W-1:0] a,
                                                 input logic [TS_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W + 1 - TS_W){1'b0}}, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  function automatic logic [CALLS_W-1:0] sat_calls(input logic [CALLS_W-1:0] a,
                                                   input logic inc);
    logic [CALLS_W:0] s;
    s = {1'b0, a} + {{CALLS_W{1'b0}}, inc};
    return s[CALLS_W] ? {CALLS_W{1'b1}} : s[CALLS_W-1:0];
  endfunction

endpackage

// ===== rtl/nested_scope_time_profiler_top.sv =====
// ----------------------------------------------------------------------------
// nested_scope_time_profiler_top: per-thread scope profiler with history ring
// Scope stacks, live statistics and archived history kept in block memories.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on in_* (tuser = op, tdata = thread, entry, timestamp,
//   slot); each word gives exactly one result word on out_* (tuser = status,
//   tdata = own, inclusive and call statistics of a history read).
//   One word is worked at a time by a read-modify-write sequencer; cost is
//   set by the single read port of the live statistics memory. A new word
//   is accepted only in the idle state. Steps worked before the result:
//     read   fetch the history row
//     begin  on overflow none; else credit any enclosing scope, push, count
//     end    on underflow none; else pop, credit the top, then any parent
//     step   a live read and a history write per entry of the thread
//   The result sits in an output register, so the next word is taken while
//   the previous result still waits; a stalled receiver only blocks once a
//   second result is ready. Reset empties all stacks, zeroes the history
//   position and clears the valid bits that make live statistics and history
//   rows read as zero, so no clearing pass is needed after reset. Stack
//   memory needs no clearing: only pushed entries are ever used.
// ----------------------------------------------------------------------------
module nested_scope_time_profiler_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // thread[1:0], entry[5:2], timestamp[37:6], slot[43:38]
  input  logic [1:0]   in_tuser,   // op[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // own_time[47:0], sum_time[95:48], call_count[127:96]
  output logic [1:0]   out_tuser   // status[1:0]
);

  localparam int LIVE_AW = nstp_pkg::TH_W + nstp_pkg::ENT_W;
  localparam int ROW_W   = nstp_pkg::TH_W + nstp_pkg::SLOT_W;
  localparam int HIST_AW = ROW_W + nstp_pkg::ENT_W;
  localparam int STKA_W  = nstp_pkg::TH_W + nstp_pkg::STK_AW;
  localparam int ST_W    = 4;

  localparam logic [ST_W-1:0] S_IDLE  = 4'd0;
  localparam logic [ST_W-1:0] S_DISP  = 4'd1;
  localparam logic [ST_W-1:0] S_BTOP  = 4'd2;
  localparam logic [ST_W-1:0] S_PUSH  = 4'd3;
  localparam logic [ST_W-1:0] S_ETOP  = 4'd4;
  localparam logic [ST_W-1:0] S_EPAR  = 4'd5;
  localparam logic [ST_W-1:0] S_LRD   = 4'd6;
  localparam logic [ST_W-1:0] S_LWR   = 4'd7;
  localparam logic [ST_W-1:0] S_SRD   = 4'd8;
  localparam logic [ST_W-1:0] S_SWR   = 4'd9;
  localparam logic [ST_W-1:0] S_HDAT  = 4'd10;
  localparam logic [ST_W-1:0] S_OUT   = 4'd11;

  // --- latched input word
  logic [1:0]                      op_r;
  logic [nstp_pkg::TH_W-1:0]       th_r;
  logic [nstp_pkg::ENT_W-1:0]      en_r;
  logic [nstp_pkg::TS_W-1:0]       ts_r;
  logic [nstp_pkg::SLOT_W-1:0]     sl_r;

  // --- control state
  logic [ST_W-1:0]                 st_r, st_nxt;
  logic [ST_W-1:0]                 ret_r;
  logic [nstp_pkg::DEPTH_W-1:0]    depth_r [nstp_pkg::THREADS];
  logic [nstp_pkg::SLOT_W-1:0]     pos_r;
  logic [nstp_pkg::ENT_W-1:0]      cnt_r;
  logic [nstp_pkg::THREADS*nstp_pkg::ENTRIES-1:0]     lvalid_r;
  logic [nstp_pkg::THREADS*nstp_pkg::HISTORY_LEN-1:0] hvalid_r;

  // --- pending live update
  logic [LIVE_AW-1:0]              ladr_r;
  logic [nstp_pkg::TS_W-1:0]       add_own_r;
  logic [nstp_pkg::TS_W-1:0]       add_sum_r;
  logic                            inc_r;

  // --- result under construction and output register
  logic [1:0]                      status_r;
  nstp_pkg::stat_rec_t             res_r;
  logic                            out_valid_r;
  nstp_pkg::stat_rec_t             out_rec_r;
  logic [1:0]                      out_stat_r;

  // --- memories
  nstp_pkg::stk_item_t             stk_mem [1 << STKA_W];
  nstp_pkg::stat_rec_t             live_mem [1 << LIVE_AW];
  nstp_pkg::stat_rec_t             hist_mem [1 << HIST_AW];

  nstp_pkg::stk_item_t             stk_q;
  nstp_pkg::stat_rec_t             live_q;
  logic                            lv_q;
  nstp_pkg::stat_rec_t             hist_q;
  logic                            hv_q;

  logic                            stk_re, stk_we;
  logic [STKA_W-1:0]               stk_ra, stk_wa;
  nstp_pkg::stk_item_t             stk_wd;
  logic                            live_re, live_we;
  logic [LIVE_AW-1:0]              live_ra;
  nstp_pkg::stat_rec_t             live_wd;
  logic                            hist_we, hist_re;
  logic [HIST_AW-1:0]              hist_wa, hist_ra;

  logic [nstp_pkg::DEPTH_W-1:0]    d_cur;
  logic [nstp_pkg::TS_W-1:0]       dt;
  nstp_pkg::stat_rec_t             live_eff;
  logic                            out_free;
  logic                            in_acc;

  assign in_acc   = in_tvalid && in_tready;
  assign in_tready = (st_r == S_IDLE);
  assign out_free = !out_valid_r || out_tready;
  assign d_cur    = depth_r[th_r];
  assign dt       = ts_r - stk_q.mark;
  assign live_eff = lv_q ? live_q : '0;

  // --- memory access decode
  always_comb begin
    stk_re  = 1'b0;
    stk_ra  = {th_r, d_cur[nstp_pkg::STK_AW-1:0] - 1'b1};
    stk_we  = 1'b0;
    stk_wa  = {th_r, d_cur[nstp_pkg::STK_AW-1:0] - 1'b1};
    stk_wd  = '{mark: ts_r, ent: stk_q.ent};
    live_re = 1'b0;
    live_ra = ladr_r;
    live_we = 1'b0;
    live_wd = '{calls: nstp_pkg::sat_calls(live_eff.calls, inc_r),
                sum:   nstp_pkg::sat_time(live_eff.sum, add_sum_r),
                own:   nstp_pkg::sat_time(live_eff.own, add_own_r)};
    hist_re = 1'b0;
    hist_ra = {th_r, sl_r, en_r};
    hist_we = 1'b0;
    hist_wa = {th_r, pos_r, cnt_r};
    case (st_r)
      S_DISP: begin
        // fetch the top of stack for begin and end, the record for a read
        stk_re  = (op_r == nstp_pkg::OP_BEGIN || op_r == nstp_pkg::OP_END);
        hist_re = (op_r == nstp_pkg::OP_READ);
      end
      S_BTOP: begin
        // restart the enclosing scope's mark
        stk_we = 1'b1;
      end
      S_PUSH: begin
        stk_we = 1'b1;
        stk_wa = {th_r, d_cur[nstp_pkg::STK_AW-1:0]};
        stk_wd = '{mark: ts_r, ent: en_r};
      end
      S_ETOP: begin
        // depth still holds the old value; fetch the new top at depth - 2
        stk_re = 1'b1;
        stk_ra = {th_r, d_cur[nstp_pkg::STK_AW-1:0] - 2'd2};
      end
      S_EPAR: begin
        stk_we = (d_cur != '0);
      end
      S_LRD: begin
        live_re = 1'b1;
      end
      S_LWR: begin
        live_we = 1'b1;
      end
      S_SRD: begin
        live_re = 1'b1;
        live_ra = {th_r, cnt_r};
      end
      S_SWR: begin
        hist_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (stk_re) begin
      stk_q <= stk_mem[stk_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (live_we) begin
      live_mem[ladr_r] <= live_wd;
    end
    if (live_re) begin
      live_q <= live_mem[live_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= live_eff;
    end
    if (hist_re) begin
      hist_q <= hist_mem[hist_ra];
    end
  end

  // --- sequencer
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (in_acc) st_nxt = S_DISP;
      S_DISP: begin
        case (op_r)
          nstp_pkg::OP_BEGIN: begin
            if (d_cur >= nstp_pkg::DEPTH_W'(nstp_pkg::STK_DEPTH)) st_nxt = S_OUT;
            else if (d_cur == '0) st_nxt = S_PUSH;
            else st_nxt = S_BTOP;
          end
          nstp_pkg::OP_END: st_nxt = (d_cur == '0) ? S_OUT : S_ETOP;
          nstp_pkg::OP_STEP: st_nxt = S_SRD;
          default: st_nxt = S_HDAT;
        endcase
      end
      S_BTOP: st_nxt = S_LRD;
      S_PUSH: st_nxt = S_LRD;
      S_ETOP: st_nxt = S_LRD;
      S_EPAR: st_nxt = (d_cur == '0) ? S_OUT : S_LRD;
      S_LRD:  st_nxt = S_LWR;
      S_LWR:  st_nxt = ret_r;
      S_SRD:  st_nxt = S_SWR;
      S_SWR:  st_nxt = (cnt_r == nstp_pkg::ENT_W'(nstp_pkg::ENTRIES - 1)) ? S_OUT : S_SRD;
      S_HDAT: st_nxt = S_OUT;
      S_OUT:  if (out_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      pos_r       <= '0;
      lvalid_r    <= '0;
      hvalid_r    <= '0;
      out_valid_r <= 1'b0;
      for (int t = 0; t < nstp_pkg::THREADS; t++) begin
        depth_r[t] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      // load a new result, or drop the one the receiver takes
      if (st_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        S_PUSH: depth_r[th_r] <= d_cur + 1'b1;
        S_ETOP: depth_r[th_r] <= d_cur - 1'b1;
        S_LWR:  lvalid_r[ladr_r] <= 1'b1;
        S_SWR: begin
          // drop the archived live entry; close the row on the last entry
          lvalid_r[{th_r, cnt_r}] <= 1'b0;
          if (cnt_r == nstp_pkg::ENT_W'(nstp_pkg::ENTRIES - 1)) begin
            hvalid_r[{th_r, pos_r}] <= 1'b1;
            pos_r <= (pos_r == nstp_pkg::SLOT_W'(nstp_pkg::HISTORY_LEN - 1)) ?
                     '0 : pos_r + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // --- datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r <= in_tuser;
      th_r <= in_tdata[1:0];
      en_r <= in_tdata[5:2];
      ts_r <= in_tdata[37:6];
      sl_r <= in_tdata[43:38];
    end
    if (live_re) begin
      lv_q <= lvalid_r[live_ra];
    end
    if (hist_re) begin
      hv_q <= hvalid_r[{th_r, sl_r}];
    end
    case (st_r)
      S_DISP: begin
        res_r    <= '0;
        status_r <= nstp_pkg::STAT_OK;
        cnt_r    <= '0;
        if (op_r == nstp_pkg::OP_BEGIN &&
            d_cur >= nstp_pkg::DEPTH_W'(nstp_pkg::STK_DEPTH)) begin
          status_r <= nstp_pkg::STAT_OVF;
        end
        if (op_r == nstp_pkg::OP_END && d_cur == '0) begin
          status_r <= nstp_pkg::STAT_UNF;
        end
      end
      S_BTOP: begin
        // credit the enclosing scope, own and inclusive
        ladr_r    <= {th_r, stk_q.ent};
        add_own_r <= dt;
        add_sum_r <= dt;
        inc_r     <= 1'b0;
        ret_r     <= S_PUSH;
      end
      S_PUSH: begin
        ladr_r    <= {th_r, en_r};
        add_own_r <= '0;
        add_sum_r <= '0;
        inc_r     <= 1'b1;
        ret_r     <= S_OUT;
      end
      S_ETOP: begin
        ladr_r    <= {th_r, stk_q.ent};
        add_own_r <= dt;
        add_sum_r <= dt;
        inc_r     <= 1'b0;
        ret_r     <= S_EPAR;
      end
      S_EPAR: begin
        // parent gains inclusive time only
        ladr_r    <= {th_r, stk_q.ent};
        add_own_r <= '0;
        add_sum_r <= dt;
        inc_r     <= 1'b0;
        ret_r     <= S_OUT;
      end
      S_SWR:  cnt_r <= cnt_r + 1'b1;
      S_HDAT: res_r <= hv_q ? hist_q : '0;
      default: begin
      end
    endcase
    if (st_r == S_OUT && out_free) begin
      out_rec_r  <= res_r;
      out_stat_r <= status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_rec_r.calls, out_rec_r.sum, out_rec_r.own};
  assign out_tuser  = out_stat_r;

  // --- checks
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> depth_r[th_r] <= nstp_pkg::DEPTH_W'(nstp_pkg::STK_DEPTH))
    else $error("stack depth beyond capacity");

  a_ovf_only_begin: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_OUT && status_r == nstp_pkg::STAT_OVF) |-> op_r == nstp_pkg::OP_BEGIN)
    else $error("overflow status on a non-begin word");

  a_data_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_OUT && op_r != nstp_pkg::OP_READ) |-> res_r == '0)
    else $error("statistics returned for a non-read word");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= nstp_pkg::SLOT_W'(nstp_pkg::HISTORY_LEN - 1))
    else $error("history position out of range");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SWR) |=> !in_tready || cnt_r == '0)
    else $error("word taken during step walk");

endmodule
